// ----- hdl/imu_gsd_pkg.sv -----
// Shared types and constants for the IMU gesture sequence detector.
package imu_gsd_pkg;

    // Number of entries in the gesture history
    localparam int unsigned HIST_DEPTH = 3;

    localparam int unsigned CODE_W = 3;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Gesture codes
    localparam logic [CODE_W-1:0] CODE_POINT_DOWN  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_POINT_UP    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_SWING_UP    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SWING_DOWN  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_ROLL_LEFT   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_ROLL_RIGHT  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SWING_THRESHOLD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTICAL_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME_MS       = 2'd2;

    // Configuration reset values
    localparam logic [14:0] SWING_THRESHOLD_RST    = 15'd1024;
    localparam logic [14:0] VERTICAL_THRESHOLD_RST = 15'd2304;
    localparam logic [15:0] HOLD_TIME_MS_RST       = 16'd100;

    // One motion sample
    typedef struct packed {
        logic signed [15:0] accel_y;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic [31:0]        time_ms;
    } sample_t;

    // One result word
    typedef struct packed {
        logic              gesture_valid;
        logic [CODE_W-1:0] gesture_code;
        logic              spell_started;
        logic              spell_ended;
        logic              spell_active;
        logic              armed;
    } result_t;

endpackage

// ----- hdl/imu_gesture_sequence_detector_unit.sv -----
// Top level of the IMU gesture sequence detector.
//
// Usage:
//   sample channel  (sample_valid/sample_ready/sample_data): one motion word
//     per handshake, carrying vertical acceleration, two gyro rates and a
//     millisecond stamp.
//   result channel  (result_valid/result_ready/result_data): exactly one
//     result word per sample, in sample order.
//   cfg channel     (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the
//     swing threshold, vertical threshold and hold time; always ready.
//     Write only while no sample is in flight.
// Pipeline: a sample accepted into the input register gives its result
//   word through the result register. Throughput: one sample per cycle
//   while result_ready stays high; the input register feeds a single level
//   of compares and the history update straight into the result register.
// Reset: clears the detector state, the history and the mode flag, and
//   loads the default thresholds.
// Stall: when result_ready is low the result register holds, the input
//   register keeps one more word, and sample_ready then drops.
module imu_gesture_sequence_detector_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  imu_gsd_pkg::sample_t                  sample_data,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output imu_gsd_pkg::result_t                  result_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [imu_gsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [imu_gsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned HD = imu_gsd_pkg::HIST_DEPTH;
    localparam int unsigned CW = imu_gsd_pkg::CODE_W;

    // Configuration registers
    logic [14:0] swing_reg;
    logic [14:0] vert_reg;
    logic [15:0] hold_reg;

    // Input stage
    logic                 in_valid_reg;
    imu_gsd_pkg::sample_t in_data_reg;

    // Detector state
    logic          armed_reg,  armed_next;
    logic [31:0]   stamp_reg,  stamp_next;
    logic [CW-1:0] hist_reg  [HD];
    logic [CW-1:0] hist_next [HD];
    logic [1:0]    fill_reg,   fill_next;
    logic          mode_reg,   mode_next;

    // Output stage
    logic                 out_valid_reg;
    imu_gsd_pkg::result_t out_data_reg, out_data_next;

    logic advance;

    // Datapath temporaries
    logic [15:0]        gx_mag, gy_mag;
    logic signed [16:0] ay_ext, vt_ext, vt_neg;
    logic               swing_hit, ay_high, ay_low;
    logic [31:0]        elapsed;
    logic               hold_done;
    logic               code_valid;
    logic [CW-1:0]      code;
    logic               started, ended;

    assign cfg_ready    = 1'b1;
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // Write configuration; unused index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swing_reg <= imu_gsd_pkg::SWING_THRESHOLD_RST;
            vert_reg  <= imu_gsd_pkg::VERTICAL_THRESHOLD_RST;
            hold_reg  <= imu_gsd_pkg::HOLD_TIME_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                imu_gsd_pkg::REG_SWING_THRESHOLD:    swing_reg <= cfg_data[14:0];
                imu_gsd_pkg::REG_VERTICAL_THRESHOLD: vert_reg  <= cfg_data[14:0];
                imu_gsd_pkg::REG_HOLD_TIME_MS:       hold_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Compares on the registered sample
    always_comb
    begin
        gx_mag    = in_data_reg.gyro_x[15] ? (~in_data_reg.gyro_x + 16'd1)
                                           : in_data_reg.gyro_x;
        gy_mag    = in_data_reg.gyro_y[15] ? (~in_data_reg.gyro_y + 16'd1)
                                           : in_data_reg.gyro_y;
        ay_ext    = {in_data_reg.accel_y[15], in_data_reg.accel_y};
        vt_ext    = {2'b00, vert_reg};
        vt_neg    = -vt_ext;
        swing_hit = (gx_mag > {1'b0, swing_reg}) || (gy_mag > {1'b0, swing_reg});
        ay_high   = ay_ext >= vt_ext;
        ay_low    = ay_ext <= vt_neg;
        elapsed   = in_data_reg.time_ms - stamp_reg;
        hold_done = elapsed > {16'd0, hold_reg};
    end

    // Arm, classify, push history and check patterns
    always_comb
    begin
        armed_next = armed_reg;
        stamp_next = stamp_reg;
        fill_next  = fill_reg;
        mode_next  = mode_reg;
        for (int i = 0; i < HD; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        code_valid = 1'b0;
        code       = imu_gsd_pkg::CODE_POINT_DOWN;
        started    = 1'b0;
        ended      = 1'b0;

        if (!armed_reg)
        begin
            if (swing_hit || ay_high || ay_low)
            begin
                armed_next = 1'b1;
                stamp_next = in_data_reg.time_ms;
            end
        end
        else if (hold_done)
        begin
            armed_next = 1'b0;
            if (ay_low && !mode_reg)
            begin
                code_valid = 1'b1;
                code       = imu_gsd_pkg::CODE_POINT_UP;
            end
            else if (ay_high)
            begin
                code_valid = 1'b1;
                code       = imu_gsd_pkg::CODE_POINT_DOWN;
            end
            else if (!mode_reg)
            begin
                code_valid = 1'b1;
                if (gx_mag > gy_mag)
                begin
                    code = (!in_data_reg.gyro_x[15] && (in_data_reg.gyro_x != 16'sd0))
                           ? imu_gsd_pkg::CODE_SWING_DOWN : imu_gsd_pkg::CODE_SWING_UP;
                end
                else
                begin
                    code = (!in_data_reg.gyro_y[15] && (in_data_reg.gyro_y != 16'sd0))
                           ? imu_gsd_pkg::CODE_ROLL_RIGHT : imu_gsd_pkg::CODE_ROLL_LEFT;
                end
            end

            if (code_valid)
            begin
                // Fill first, then drop the oldest and shift down
                if (fill_reg < 2'(HD))
                begin
                    for (int i = 0; i < HD; i++)
                    begin
                        if (fill_reg == 2'(i))
                        begin
                            hist_next[i] = code;
                        end
                    end
                    fill_next = fill_reg + 2'd1;
                end
                else
                begin
                    for (int i = 0; i < HD - 1; i++)
                    begin
                        hist_next[i] = hist_reg[i + 1];
                    end
                    hist_next[HD - 1] = code;
                end

                if ((hist_next[0] == imu_gsd_pkg::CODE_POINT_UP) &&
                    (((hist_next[1] == imu_gsd_pkg::CODE_SWING_UP) &&
                      (hist_next[2] == imu_gsd_pkg::CODE_POINT_UP)) ||
                     ((hist_next[1] == imu_gsd_pkg::CODE_SWING_DOWN) &&
                      (hist_next[2] == imu_gsd_pkg::CODE_SWING_UP))))
                begin
                    mode_next = 1'b1;
                    started   = 1'b1;
                end
                if (mode_next &&
                    (hist_next[0] == imu_gsd_pkg::CODE_POINT_DOWN) &&
                    (hist_next[1] == imu_gsd_pkg::CODE_POINT_DOWN) &&
                    (hist_next[2] == imu_gsd_pkg::CODE_POINT_DOWN))
                begin
                    mode_next = 1'b0;
                    ended     = 1'b1;
                end
            end
        end

        out_data_next.gesture_valid = code_valid;
        out_data_next.gesture_code  = code;
        out_data_next.spell_started = started;
        out_data_next.spell_ended   = ended;
        out_data_next.spell_active  = mode_next;
        out_data_next.armed         = armed_next;
    end

    // Hold the accepted sample until it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            in_data_reg <= sample_data;
        end
    end

    // Update detector state on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            stamp_reg <= 32'd0;
            fill_reg  <= 2'd0;
            mode_reg  <= 1'b0;
            for (int i = 0; i < HD; i++)
            begin
                hist_reg[i] <= imu_gsd_pkg::CODE_POINT_DOWN;
            end
        end
        else if (advance)
        begin
            armed_reg <= armed_next;
            stamp_reg <= stamp_next;
            fill_reg  <= fill_next;
            mode_reg  <= mode_next;
            for (int i = 0; i < HD; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    // Present the result word; drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the IMU gesture sequence detector unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [imu_gsd_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_WORDS   = 225;
    localparam int LONG_HOLD_OFF = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;

    // Tracks detector state and holds the result words still to arrive
    class gesture_scoreboard;
        bit [14:0]                     swing_thr;
        bit [14:0]                     vert_thr;
        bit [15:0]                     hold_ms;
        bit                            armed_now;
        bit [31:0]                     arm_stamp;
        bit [imu_gsd_pkg::CODE_W-1:0]  hist [imu_gsd_pkg::HIST_DEPTH];
        int                            fill;
        bit                            spell_on;
        imu_gsd_pkg::result_t          results_due [$];
        int                            mismatches;

        function new();
            swing_thr  = imu_gsd_pkg::SWING_THRESHOLD_RST;
            vert_thr   = imu_gsd_pkg::VERTICAL_THRESHOLD_RST;
            hold_ms    = imu_gsd_pkg::HOLD_TIME_MS_RST;
            armed_now  = 1'b0;
            arm_stamp  = '0;
            fill       = 0;
            spell_on   = 1'b0;
            mismatches = 0;
            foreach (hist[i])
                hist[i] = '0;
        endfunction

        function void write_register(logic [imu_gsd_pkg::CFG_INDEX_W-1:0] idx,
                                     logic [imu_gsd_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                imu_gsd_pkg::REG_SWING_THRESHOLD:    swing_thr = d[14:0];
                imu_gsd_pkg::REG_VERTICAL_THRESHOLD: vert_thr  = d[14:0];
                imu_gsd_pkg::REG_HOLD_TIME_MS:       hold_ms   = d;
                default: ;
            endcase
        endfunction

        // Advance the detector by one sample and return its result word
        function imu_gsd_pkg::result_t predict_gesture(imu_gsd_pkg::sample_t s);
            int                   ay;
            int                   gx;
            int                   gy;
            int                   mag_x;
            int                   mag_y;
            int                   st;
            int                   vt;
            bit [31:0]            elapsed;
            imu_gsd_pkg::result_t r;
            r     = '0;
            ay    = $signed(s.accel_y);
            gx    = $signed(s.gyro_x);
            gy    = $signed(s.gyro_y);
            mag_x = (gx < 0) ? -gx : gx;
            mag_y = (gy < 0) ? -gy : gy;
            st    = int'(swing_thr);
            vt    = int'(vert_thr);
            if (!armed_now)
            begin
                if (mag_x > st || mag_y > st || ay >= vt || ay <= -vt)
                begin
                    armed_now = 1'b1;
                    arm_stamp = s.time_ms;
                end
            end
            else
            begin
                elapsed = s.time_ms - arm_stamp;
                if (elapsed > 32'(hold_ms))
                begin
                    // pointing wins over swing and roll
                    if (ay <= -vt && !spell_on)
                    begin
                        r.gesture_valid = 1'b1;
                        r.gesture_code  = imu_gsd_pkg::CODE_POINT_UP;
                    end
                    else if (ay >= vt)
                    begin
                        r.gesture_valid = 1'b1;
                        r.gesture_code  = imu_gsd_pkg::CODE_POINT_DOWN;
                    end
                    else if (!spell_on)
                    begin
                        r.gesture_valid = 1'b1;
                        if (mag_x > mag_y)
                            r.gesture_code = (gx > 0) ? imu_gsd_pkg::CODE_SWING_DOWN
                                                      : imu_gsd_pkg::CODE_SWING_UP;
                        else
                            r.gesture_code = (gy > 0) ? imu_gsd_pkg::CODE_ROLL_RIGHT
                                                      : imu_gsd_pkg::CODE_ROLL_LEFT;
                    end
                    armed_now = 1'b0;

                    if (r.gesture_valid)
                    begin
                        // fill the history first, then shift the oldest out
                        if (fill < imu_gsd_pkg::HIST_DEPTH)
                        begin
                            hist[fill] = r.gesture_code;
                            fill++;
                        end
                        else
                        begin
                            for (int i = 0; i + 1 < imu_gsd_pkg::HIST_DEPTH; i++)
                                hist[i] = hist[i + 1];
                            hist[imu_gsd_pkg::HIST_DEPTH - 1] = r.gesture_code;
                        end
                        if (hist[0] == imu_gsd_pkg::CODE_POINT_UP &&
                            ((hist[1] == imu_gsd_pkg::CODE_SWING_UP &&
                              hist[2] == imu_gsd_pkg::CODE_POINT_UP) ||
                             (hist[1] == imu_gsd_pkg::CODE_SWING_DOWN &&
                              hist[2] == imu_gsd_pkg::CODE_SWING_UP)))
                        begin
                            spell_on        = 1'b1;
                            r.spell_started = 1'b1;
                        end
                        if (spell_on && hist[0] == imu_gsd_pkg::CODE_POINT_DOWN &&
                            hist[1] == imu_gsd_pkg::CODE_POINT_DOWN &&
                            hist[2] == imu_gsd_pkg::CODE_POINT_DOWN)
                        begin
                            spell_on      = 1'b0;
                            r.spell_ended = 1'b1;
                        end
                    end
                end
            end
            r.spell_active = spell_on;
            r.armed        = armed_now;
            return r;
        endfunction

        function void note_sample(imu_gsd_pkg::sample_t s);
            results_due.push_back(predict_gesture(s));
        endfunction

        function string describe(imu_gsd_pkg::result_t r);
            return $sformatf("valid=%0b code=%0d started=%0b ended=%0b active=%0b armed=%0b",
                             r.gesture_valid, r.gesture_code, r.spell_started,
                             r.spell_ended, r.spell_active, r.armed);
        endfunction

        function void check_result(imu_gsd_pkg::result_t got);
            imu_gsd_pkg::result_t want;
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: %s", describe(got));
                return;
            end
            want = results_due.pop_front();
            if (got.gesture_valid !== want.gesture_valid ||
                got.gesture_code  !== want.gesture_code  ||
                got.spell_started !== want.spell_started ||
                got.spell_ended   !== want.spell_ended   ||
                got.spell_active  !== want.spell_active  ||
                got.armed         !== want.armed)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch at %0t: expected %s, got %s",
                             $realtime, describe(want), describe(got));
            end
        endfunction
    endclass

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  sample_valid;
    logic                                  sample_ready;
    imu_gsd_pkg::sample_t                  sample_data;
    logic                                  result_valid;
    logic                                  result_ready;
    imu_gsd_pkg::result_t                  result_data;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [imu_gsd_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [imu_gsd_pkg::CFG_DATA_W-1:0]    cfg_data;

    int        sender_idle_pct = 0;
    int        stall_pct       = 0;
    int        long_stall      = 0;
    int        words_sent      = 0;
    bit [31:0] now_ms          = '0;

    gesture_scoreboard board = new();

    imu_gesture_sequence_detector_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4ns clk = ~clk;

    // Clamp to the signed 16-bit range
    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic int small_val();
        return int'($urandom_range(0, 510)) - 255;
    endfunction

    function automatic imu_gsd_pkg::sample_t noise_sample(bit [31:0] t);
        imu_gsd_pkg::sample_t s;
        s.accel_y = 16'($urandom);
        s.gyro_x  = 16'($urandom);
        s.gyro_y  = 16'($urandom);
        s.time_ms = t;
        return s;
    endfunction

    // Build a classifying sample that aims at one gesture code
    function automatic imu_gsd_pkg::sample_t aimed_sample(
        logic [imu_gsd_pkg::CODE_W-1:0] code, bit [31:0] t);
        imu_gsd_pkg::sample_t s;
        int                   vt;
        int                   big;
        int                   minor;
        vt        = int'(board.vert_thr);
        s.time_ms = t;
        s.gyro_x  = sat16(small_val());
        s.gyro_y  = sat16(small_val());
        s.accel_y = (vt > 0) ? sat16(int'($urandom_range(0, 2 * vt - 2)) - (vt - 1)) : '0;
        big       = int'($urandom_range(1, 32767));
        case (code) inside
            imu_gsd_pkg::CODE_POINT_UP:
                s.accel_y = sat16(-vt - int'($urandom_range(0, 3000)));
            imu_gsd_pkg::CODE_POINT_DOWN:
                s.accel_y = sat16(vt + int'($urandom_range(0, 3000)));
            imu_gsd_pkg::CODE_SWING_UP, imu_gsd_pkg::CODE_SWING_DOWN:
            begin
                minor    = int'($urandom_range(0, big - 1));
                s.gyro_x = sat16((code == imu_gsd_pkg::CODE_SWING_DOWN) ? big : -big);
                s.gyro_y = sat16($urandom_range(1) ? minor : -minor);
            end
            default:
            begin
                minor    = int'($urandom_range(0, big));
                s.gyro_y = sat16((code == imu_gsd_pkg::CODE_ROLL_RIGHT) ? big : -big);
                s.gyro_x = sat16($urandom_range(1) ? minor : -minor);
            end
        endcase
        return s;
    endfunction

    // Offer one sample word and wait for it to be taken
    task automatic offer_sample(imu_gsd_pkg::sample_t s);
        @(negedge clk);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        board.note_sample(s);
        words_sent++;
    endtask

    task automatic put(logic signed [15:0] ay, logic signed [15:0] gx,
                       logic signed [15:0] gy, bit [31:0] t);
        imu_gsd_pkg::sample_t s;
        s.accel_y = ay;
        s.gyro_x  = gx;
        s.gyro_y  = gy;
        s.time_ms = t;
        offer_sample(s);
    endtask

    // Arm on one gyro axis or on vertical acceleration
    task automatic arm_sample(bit [31:0] t);
        imu_gsd_pkg::sample_t s;
        int                   mag;
        int                   vt;
        vt        = int'(board.vert_thr);
        mag       = int'(board.swing_thr) + 1 + int'($urandom_range(0, 2000));
        s.accel_y = sat16(small_val());
        s.gyro_x  = sat16(small_val());
        s.gyro_y  = sat16(small_val());
        s.time_ms = t;
        case ($urandom_range(3))
            0: s.gyro_x = sat16($urandom_range(1) ? mag : -mag);
            1: s.gyro_y = sat16($urandom_range(1) ? mag : -mag);
            2: s.accel_y = sat16(vt + int'($urandom_range(0, 2000)));
            default: s.accel_y = sat16(-vt - int'($urandom_range(0, 2000)));
        endcase
        offer_sample(s);
    endtask

    // Arm, idle within the hold time, then classify past it
    task automatic perform_gesture(logic [imu_gsd_pkg::CODE_W-1:0] code, int max_extra);
        bit [31:0] t0;
        int        extra;
        t0 = now_ms + $urandom_range(1, 50);
        arm_sample(t0);
        extra = $urandom_range(0, max_extra);
        repeat (extra)
            offer_sample(noise_sample(t0 + $urandom_range(0, board.hold_ms)));
        now_ms = t0 + board.hold_ms + 1 + $urandom_range(0, 40);
        offer_sample(aimed_sample(code, now_ms));
    endtask

    task automatic play_random_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            if ($urandom_range(4) == 0)
                now_ms = $urandom;
            else
                now_ms = now_ms + $urandom_range(0, 2 * board.hold_ms + 5);
            offer_sample(noise_sample(now_ms));
        end
        else if (pick < 37)
        begin
            perform_gesture(imu_gsd_pkg::CODE_POINT_UP, 2);
            perform_gesture(imu_gsd_pkg::CODE_SWING_UP, 2);
            perform_gesture(imu_gsd_pkg::CODE_POINT_UP, 2);
        end
        else if (pick < 47)
        begin
            perform_gesture(imu_gsd_pkg::CODE_POINT_UP, 2);
            perform_gesture(imu_gsd_pkg::CODE_SWING_DOWN, 2);
            perform_gesture(imu_gsd_pkg::CODE_SWING_UP, 2);
        end
        else if (pick < 57)
        begin
            repeat (3)
                perform_gesture(imu_gsd_pkg::CODE_POINT_DOWN, 2);
        end
        else
            perform_gesture(3'($urandom_range(0, 5)), 2);
    endtask

    task automatic run_directed();
        bit [31:0] t0;
        // gyro values equal to the swing threshold and acceleration just below the vertical threshold do not arm
        now_ms = 32'hFFFF_FFC0;
        put(16'sd2303, 16'sd1024, -16'sd1024, now_ms);
        // most negative gyro arms just before the stamp wraps
        t0 = now_ms + 1;
        put(16'sd0, 16'sh8000, 16'sd0, t0);
        put(-16'sd2304, 16'sd0, 16'sd0, t0 + 100);
        now_ms = t0 + 101;
        put(-16'sd2304, 16'sd0, 16'sd0, now_ms);
        // point up, swing up, point up starts spell mode
        perform_gesture(imu_gsd_pkg::CODE_SWING_UP, 0);
        perform_gesture(imu_gsd_pkg::CODE_POINT_UP, 0);
        // while active, point up gives no code, and three point downs end it
        perform_gesture(imu_gsd_pkg::CODE_POINT_UP, 0);
        repeat (3)
            perform_gesture(imu_gsd_pkg::CODE_POINT_DOWN, 0);
        // equal gyro magnitudes fall through to roll left
        now_ms = now_ms + 7;
        put(16'sd3000, 16'sd0, 16'sd0, now_ms);
        now_ms = now_ms + 101;
        put(16'sd0, 16'sd500, -16'sd500, now_ms);
        perform_gesture(imu_gsd_pkg::CODE_ROLL_RIGHT, 0);
        // point up, swing down, swing up starts spell mode too
        perform_gesture(imu_gsd_pkg::CODE_POINT_UP, 0);
        perform_gesture(imu_gsd_pkg::CODE_SWING_DOWN, 0);
        perform_gesture(imu_gsd_pkg::CODE_SWING_UP, 0);
    endtask

    task automatic write_register(logic [imu_gsd_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [imu_gsd_pkg::CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_register(idx, d);
    endtask

    task automatic program_phase(int phase);
        bit [14:0] sw;
        bit [14:0] vt;
        bit [15:0] hold;
        sw   = 15'($urandom_range(256, 4096));
        vt   = 15'($urandom_range(256, 8192));
        hold = 16'($urandom_range(0, 300));
        case (phase)
            1:
            begin
                sw   = '0;
                vt   = '0;
                hold = '0;
            end
            2:
            begin
                sw   = '1;
                vt   = '1;
                hold = '1;
            end
            3:
            begin
                sw   = imu_gsd_pkg::SWING_THRESHOLD_RST;
                vt   = imu_gsd_pkg::VERTICAL_THRESHOLD_RST;
                hold = imu_gsd_pkg::HOLD_TIME_MS_RST;
            end
            7:
            begin
                sw   = 15'($urandom);
                vt   = 15'($urandom);
                hold = 16'($urandom_range(0, 2000));
            end
            default: ;
        endcase
        write_register(REG_SPARE, 16'($urandom));
        write_register(imu_gsd_pkg::REG_SWING_THRESHOLD, {1'($urandom), sw});
        write_register(imu_gsd_pkg::REG_VERTICAL_THRESHOLD, {1'($urandom), vt});
        write_register(imu_gsd_pkg::REG_HOLD_TIME_MS, hold);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (board.results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Main sequence: reset, directed words, then phases of random gestures
    initial
    begin
        int  quota;
        bit  held_off;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_data  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                drain_results();
                program_phase(phase);
            end
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1:
                begin
                    sender_idle_pct = 74;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 74;
                end
                default:
                begin
                    sender_idle_pct = 19;
                    stall_pct       = 19;
                end
            endcase
            quota    = words_sent + PHASE_WORDS;
            held_off = 1'b0;
            if (phase == 0)
                run_directed();
            while (words_sent < quota)
            begin
                // hold the receiver off while samples keep coming
                if (!held_off && words_sent >= quota - PHASE_WORDS / 2)
                begin
                    long_stall = LONG_HOLD_OFF;
                    held_off   = 1'b1;
                end
                play_random_step();
            end
        end
        drain_results();

        if (board.mismatches == 0 && board.results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Result side: random stalls plus the occasional long hold-off
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall > 0)
            begin
                result_ready <= 1'b0;
                long_stall--;
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check each result word as it is taken
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(result_data);
    end

    // Give up on a hung run
    initial
    begin
        #4ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
